FILE: rtl/core/gdda_pkg.sv
// Shared types, codes and calendar helper functions for the date arithmetic unit.
package gdda_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ADD   = 2'd1,
      OP_SUB   = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_MONTH = 2'd1,
      STATUS_BAD_DAY   = 2'd2,
      STATUS_BAD_YEAR  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_WALK,
      ST_COMMIT,
      ST_MJD1,
      ST_MJD2,
      ST_MJD3,
      ST_MJD4,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic check;
      logic walk;
      logic commit;
      logic mjd1;
      logic mjd2;
      logic mjd3;
      logic mjd4;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_load;
      logic walk_done;
      logic out_free;
   } sts_type;

   localparam logic [13:0] YEAR_MIN       = 14'd1;
   localparam logic [13:0] YEAR_MAX       = 14'd9999;
   localparam logic [13:0] RESET_YEAR     = 14'd1970;
   localparam logic [3:0]  RESET_MONTH    = 4'd1;
   localparam logic [4:0]  RESET_DAY      = 5'd1;
   localparam logic [3:0]  MONTH_JAN      = 4'd1;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  MONTH_DEC      = 4'd12;
   localparam logic [14:0] YEAR_EPOCH     = 15'd4800;
   // 32045 + 2400001: JDN base plus the MJD shift
   localparam logic [24:0] MJD_OFFSET     = 25'd2432046;
   localparam logic [26:0] RECIP25        = 27'd5243;   // ceil(2^17 / 25)

   // Exact floor(x / 25) for any 14-bit x
   function automatic logic [9:0] div25(input logic [13:0] x);
      logic [26:0] p;
      p = 27'(x) * RECIP25;
      return p[26:17];
   endfunction

   function automatic logic year_is_leap(input logic [13:0] y);
      logic [9:0]  q;
      logic [13:0] r;
      q = div25(y);
      r = y - 14'(14'(q) * 14'd25);
      return (y[1:0] == 2'b00) && ((r != 14'd0) || (y[3:0] == 4'b0000));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m) inside
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

   // Days before month index mo of a March-based year: (153*mo+2)/5
   function automatic logic [8:0] month_offset(input logic [3:0] mo);
      logic [8:0] v;
      case (mo)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/gdda_ctrl.sv
// Sequencing state machine for the date arithmetic unit.
module gdda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gdda_pkg::sts_type   sts,
   output gdda_pkg::cmd_type   cmd
);

   gdda_pkg::state_type state_ff;
   gdda_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gdda_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = gdda_pkg::ST_SETUP;
            end
         end
         gdda_pkg::ST_SETUP: begin
            state_in = sts.is_load ? gdda_pkg::ST_CHECK : gdda_pkg::ST_WALK;
         end
         gdda_pkg::ST_CHECK: begin
            state_in = gdda_pkg::ST_COMMIT;
         end
         gdda_pkg::ST_WALK: begin
            if (sts.walk_done) begin
               state_in = gdda_pkg::ST_COMMIT;
            end
         end
         gdda_pkg::ST_COMMIT: begin
            state_in = gdda_pkg::ST_MJD1;
         end
         gdda_pkg::ST_MJD1: begin
            state_in = gdda_pkg::ST_MJD2;
         end
         gdda_pkg::ST_MJD2: begin
            state_in = gdda_pkg::ST_MJD3;
         end
         gdda_pkg::ST_MJD3: begin
            state_in = gdda_pkg::ST_MJD4;
         end
         gdda_pkg::ST_MJD4: begin
            state_in = gdda_pkg::ST_EMIT;
         end
         gdda_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               state_in = gdda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gdda_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         gdda_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         gdda_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
         end
         gdda_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         gdda_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         gdda_pkg::ST_MJD1: begin
            cmd.mjd1 = 1'b1;
         end
         gdda_pkg::ST_MJD2: begin
            cmd.mjd2 = 1'b1;
         end
         gdda_pkg::ST_MJD3: begin
            cmd.mjd3 = 1'b1;
         end
         gdda_pkg::ST_MJD4: begin
            cmd.mjd4 = 1'b1;
         end
         gdda_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/core/gdda_datapath.sv
// Date registers, month walk, load check, MJD pipeline and result register.
module gdda_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gdda_pkg::cmd_type   cmd,
   output gdda_pkg::sts_type   sts,
   input  logic [1:0]          opcode,
   input  logic [13:0]         load_year,
   input  logic [3:0]          load_month,
   input  logic [4:0]          load_day,
   input  logic [11:0]         day_delta,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   // Stored date
   logic [13:0] date_year_ff, date_year_in;
   logic [3:0]  date_month_ff, date_month_in;
   logic [4:0]  date_day_ff, date_day_in;

   // Working date during one request
   gdda_pkg::opcode_type  op_ff, op_in;
   logic [13:0]           year_ff, year_in;
   logic [3:0]            month_ff, month_in;
   logic signed [13:0]    day_ff, day_in;
   logic                  leap_ff;
   gdda_pkg::status_type  status_ff, status_in;
   logic                  err_ff, err_in;

   // MJD pipeline
   logic [14:0] ye_ff, ye_in;
   logic [9:0]  dterm_ff, dterm_in;
   logic [9:0]  q100_ff, q100_in;
   logic [9:0]  q400_ff, q400_in;
   logic [23:0] lin_ff, lin_in;
   logic [22:0] mjd_ff, mjd_in;
   logic [24:0] mjd_sum;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic [4:0]  len_cur;
   logic [3:0]  month_prev;
   logic [4:0]  len_prev;
   logic        feb_or_jan;
   logic [3:0]  march_index;

   assign len_cur    = gdda_pkg::month_len(month_ff, leap_ff);
   assign month_prev = (month_ff == gdda_pkg::MONTH_JAN) ? gdda_pkg::MONTH_DEC
                                                         : month_ff - 4'd1;
   assign len_prev   = gdda_pkg::month_len(month_prev, leap_ff);

   assign sts.is_load   = (op_ff == gdda_pkg::OP_LOAD);
   assign sts.walk_done = err_ff ||
                          ((op_ff == gdda_pkg::OP_SUB) ? (day_ff >= 14'sd1)
                                                       : (day_ff <= $signed({9'd0, len_cur})));
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   // Leap flag is registered from the working year; a February is never
   // reached in the cycle right after a year change.
   always_ff @(posedge clock) begin
      leap_ff <= gdda_pkg::year_is_leap(year_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         date_year_ff  <= gdda_pkg::RESET_YEAR;
         date_month_ff <= gdda_pkg::RESET_MONTH;
         date_day_ff   <= gdda_pkg::RESET_DAY;
         rsp_valid_ff  <= 1'b0;
      end else begin
         date_year_ff  <= date_year_in;
         date_month_ff <= date_month_in;
         date_day_ff   <= date_day_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      year_ff     <= year_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      status_ff   <= status_in;
      err_ff      <= err_in;
      ye_ff       <= ye_in;
      dterm_ff    <= dterm_in;
      q100_ff     <= q100_in;
      q400_ff     <= q400_in;
      lin_ff      <= lin_in;
      mjd_ff      <= mjd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Working date: capture, load check and month walk
   always_comb begin
      op_in     = op_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      status_in = status_ff;
      err_in    = err_ff;

      if (cmd.capture) begin
         op_in     = gdda_pkg::opcode_type'(opcode);
         status_in = gdda_pkg::STATUS_OK;
         err_in    = 1'b0;
         case (gdda_pkg::opcode_type'(opcode))
            gdda_pkg::OP_LOAD: begin
               year_in  = load_year;
               month_in = load_month;
               day_in   = $signed({9'd0, load_day});
            end
            gdda_pkg::OP_ADD: begin
               year_in  = date_year_ff;
               month_in = date_month_ff;
               day_in   = $signed(14'(date_day_ff) + 14'(day_delta));
            end
            gdda_pkg::OP_SUB: begin
               year_in  = date_year_ff;
               month_in = date_month_ff;
               day_in   = $signed(14'(date_day_ff) - 14'(day_delta));
            end
            default: begin
               year_in  = date_year_ff;
               month_in = date_month_ff;
               day_in   = $signed({9'd0, date_day_ff});
            end
         endcase
      end else if (cmd.check) begin
         if ((month_ff < gdda_pkg::MONTH_JAN) || (month_ff > gdda_pkg::MONTH_DEC)) begin
            status_in = gdda_pkg::STATUS_BAD_MONTH;
         end else if ((day_ff < 14'sd1) || (day_ff > $signed({9'd0, len_cur}))) begin
            status_in = gdda_pkg::STATUS_BAD_DAY;
         end else if ((year_ff < gdda_pkg::YEAR_MIN) || (year_ff > gdda_pkg::YEAR_MAX)) begin
            status_in = gdda_pkg::STATUS_BAD_YEAR;
         end
      end else if (cmd.walk && !sts.walk_done) begin
         if (op_ff == gdda_pkg::OP_SUB) begin
            // Step back one month; the year can only fall, so hitting
            // year zero ends the walk with an error
            if ((month_ff == gdda_pkg::MONTH_JAN) && (year_ff == gdda_pkg::YEAR_MIN)) begin
               err_in    = 1'b1;
               status_in = gdda_pkg::STATUS_BAD_YEAR;
            end else begin
               month_in = month_prev;
               if (month_ff == gdda_pkg::MONTH_JAN) begin
                  year_in = year_ff - 14'd1;
               end
               day_in = day_ff + $signed({9'd0, len_prev});
            end
         end else begin
            // Step forward one month; passing year 9999 is final
            if ((month_ff == gdda_pkg::MONTH_DEC) && (year_ff == gdda_pkg::YEAR_MAX)) begin
               err_in    = 1'b1;
               status_in = gdda_pkg::STATUS_BAD_YEAR;
            end else begin
               day_in = day_ff - $signed({9'd0, len_cur});
               if (month_ff == gdda_pkg::MONTH_DEC) begin
                  month_in = gdda_pkg::MONTH_JAN;
                  year_in  = year_ff + 14'd1;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
      end
   end

   // Stored date update
   always_comb begin
      date_year_in  = date_year_ff;
      date_month_in = date_month_ff;
      date_day_in   = date_day_ff;
      if (cmd.commit && (status_ff == gdda_pkg::STATUS_OK)) begin
         date_year_in  = year_ff;
         date_month_in = month_ff;
         date_day_in   = day_ff[4:0];
      end
   end

   // MJD of the stored date over four steps
   assign feb_or_jan  = (date_month_ff <= gdda_pkg::MONTH_FEB);
   assign march_index = feb_or_jan ? date_month_ff + 4'd9 : date_month_ff - 4'd3;
   assign mjd_sum     = 25'(lin_ff) - 25'(q100_ff) + 25'(q400_ff) + 25'(dterm_ff)
                        - gdda_pkg::MJD_OFFSET;

   always_comb begin
      ye_in    = ye_ff;
      dterm_in = dterm_ff;
      q100_in  = q100_ff;
      q400_in  = q400_ff;
      lin_in   = lin_ff;
      mjd_in   = mjd_ff;
      if (cmd.mjd1) begin
         ye_in    = 15'(date_year_ff) + gdda_pkg::YEAR_EPOCH - 15'(feb_or_jan);
         dterm_in = 10'(gdda_pkg::month_offset(march_index)) + 10'(date_day_ff);
      end
      if (cmd.mjd2) begin
         q100_in = gdda_pkg::div25(14'(ye_ff >> 2));
      end
      if (cmd.mjd3) begin
         q400_in = gdda_pkg::div25(14'(ye_ff >> 4));
         lin_in  = 24'(ye_ff) * 24'd365 + 24'(ye_ff >> 2);
      end
      if (cmd.mjd4) begin
         mjd_in = mjd_sum[22:0];
      end
   end

   // Result register: hold until taken, refill on emit
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, mjd_ff, date_day_ff, date_month_ff, date_year_ff};
         rsp_user_in  = status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/core/gregorian_date_day_arithmetic_unit.sv
// Top level of the Gregorian date keeper with day add, subtract and MJD output.
//
// Usage:
//   Request channel (req_*): one request per handshake. req_tuser carries the
//   opcode (load, add days, subtract days, query); req_tdata carries the date
//   to load and the day count. Load checks month, day and year in that order.
//   Result channel (rsp_*): exactly one result per request, in order. rsp_tdata
//   holds the stored date after the step and its modified Julian day;
//   rsp_tuser holds the status. A failed step leaves the stored date as is.
// Sequence: setup, then the load check or the month walk, then commit, four
//   MJD steps and emit. The walk covers k months (k = 0 for load and query, up
//   to about 136 for a day count of 4095) and steps one month per cycle; emit
//   waits until the output register is free.
// Flow: one request at a time; req_tready is high only while idle. A finished
//   result waits in the output register, so a stalled receiver does not block
//   the next request until its result is ready to be written.
// Reset: synchronous, active high; the stored date returns to 1970-01-01
//   and both channels go idle.
module gregorian_date_day_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [13:0] load_year, [17:14] load_month, [22:18] load_day,
   // [34:23] day_delta, [39:35] zero
   input  logic [39:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day,
   // [45:23] mjd (signed), [47:46] zero
   output logic [47:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser
);

   gdda_pkg::cmd_type cmd;
   gdda_pkg::sts_type sts;

   // Sequence the steps of one request
   gdda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold the date, walk months, compute the MJD, drive the result
   gdda_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .opcode     (req_tuser),
      .load_year  (req_tdata[13:0]),
      .load_month (req_tdata[17:14]),
      .load_day   (req_tdata[22:18]),
      .day_delta  (req_tdata[34:23]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the Gregorian date day arithmetic unit.
`timescale 1ns / 1ps

module testbench;

   localparam int CLOCK_HALF_NS    = 4;
   localparam int RESET_CYCLES     = 4;
   localparam int MAX_GAP          = 17;
   localparam int LONG_HOLD_CYCLES = 600;
   // Longest month walk plus MJD and emit, with margin
   localparam int DRAIN_CYCLES     = 300;
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int RANDOM_ITEMS     = 1550;

   typedef struct {
      logic [13:0]          year;
      logic [3:0]           month;
      logic [4:0]           day;
      logic signed [22:0]   mjd;
      gdda_pkg::status_type status;
   } date_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [13:0] load_year, [17:14] load_month, [22:18] load_day, [34:23] day_delta
   logic [39:0] req_tdata  = '0;
   // [1:0] opcode
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day, [45:23] mjd
   logic [47:0] rsp_tdata;
   // [1:0] status
   logic [1:0]  rsp_tuser;

   // Predicted stored date
   logic [13:0] cal_year;
   logic [3:0]  cal_month;
   logic [4:0]  cal_day;

   date_result_type expected_dates[$];

   bit req_gaps_on   = 1'b1;
   bit rsp_gaps_on   = 1'b1;
   bit rsp_long_hold = 1'b0;

   int mismatch_count = 0;
   int results_seen   = 0;
   int cycle_count    = 0;
   int op_counts[4]   = '{default: 0};
   int status_hits[4] = '{default: 0};

   gregorian_date_day_arithmetic_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   // ---------------------------------------------------------------- calendar

   function automatic bit is_leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_days(input int m, input int y);
      case (m)
         2:             return is_leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic int mjd_of_date(input int y, input int m, input int d);
      int a;
      int ye;
      int mo;
      a  = (14 - m) / 12;
      ye = y + 4800 - a;
      mo = m + 12 * a - 3;
      return d + (153 * mo + 2) / 5 + 365 * ye + ye / 4 - ye / 100 + ye / 400
             - 32045 - 2400001;
   endfunction

   // Apply one request to the predicted date and return the result it yields
   function automatic date_result_type apply_calendar_step(
      input gdda_pkg::opcode_type op,
      input logic [13:0]          ly,
      input logic [3:0]           lm,
      input logic [4:0]           ld,
      input logic [11:0]          delta
   );
      int                   y;
      int                   m;
      int                   d;
      int                   n;
      gdda_pkg::status_type st;
      date_result_type      r;
      y  = int'(cal_year);
      m  = int'(cal_month);
      d  = int'(cal_day);
      n  = int'(delta);
      st = gdda_pkg::STATUS_OK;
      case (op)
         gdda_pkg::OP_LOAD: begin
            if (int'(lm) < 1 || int'(lm) > 12) begin
               st = gdda_pkg::STATUS_BAD_MONTH;
            end else if (int'(ld) < 1 || int'(ld) > month_days(int'(lm), int'(ly))) begin
               st = gdda_pkg::STATUS_BAD_DAY;
            end else if (ly < gdda_pkg::YEAR_MIN || ly > gdda_pkg::YEAR_MAX) begin
               st = gdda_pkg::STATUS_BAD_YEAR;
            end else begin
               y = int'(ly);
               m = int'(lm);
               d = int'(ld);
            end
         end
         gdda_pkg::OP_ADD: begin
            d = d + n;
            while (d > month_days(m, y)) begin
               d = d - month_days(m, y);
               m++;
               if (m > 12) begin
                  m = 1;
                  y++;
               end
            end
            if (y > int'(gdda_pkg::YEAR_MAX)) st = gdda_pkg::STATUS_BAD_YEAR;
         end
         gdda_pkg::OP_SUB: begin
            d = d - n;
            while (d < 1) begin
               m--;
               if (m < 1) begin
                  m = 12;
                  y--;
               end
               d = d + month_days(m, y);
            end
            if (y < int'(gdda_pkg::YEAR_MIN)) st = gdda_pkg::STATUS_BAD_YEAR;
         end
         default: begin
         end
      endcase
      if (st == gdda_pkg::STATUS_OK) begin
         cal_year  = 14'(y);
         cal_month = 4'(m);
         cal_day   = 5'(d);
      end
      r.year   = cal_year;
      r.month  = cal_month;
      r.day    = cal_day;
      r.mjd    = 23'(mjd_of_date(int'(cal_year), int'(cal_month), int'(cal_day)));
      r.status = st;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      $display("[%0t] mismatch on result %0d: %s expected %0d, got %0d",
               $time, results_seen, field, want, got);
   endtask

   always @(posedge clock) begin : result_checker
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_dates.size() == 0) begin
            report_mismatch("result with no request outstanding", 0, int'(rsp_tdata[13:0]));
         end else begin
            want = expected_dates.pop_front();
            status_hits[want.status]++;
            if (rsp_tdata[13:0] !== want.year)
               report_mismatch("cur_year", int'(want.year), int'(rsp_tdata[13:0]));
            if (rsp_tdata[17:14] !== want.month)
               report_mismatch("cur_month", int'(want.month), int'(rsp_tdata[17:14]));
            if (rsp_tdata[22:18] !== want.day)
               report_mismatch("cur_day", int'(want.day), int'(rsp_tdata[22:18]));
            if (rsp_tdata[45:23] !== want.mjd)
               report_mismatch("mjd", int'(want.mjd), int'($signed(rsp_tdata[45:23])));
            if (rsp_tuser !== want.status)
               report_mismatch("status", int'(want.status), int'(rsp_tuser));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, expected_dates.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- receiver

   // After each accepted result, hold rsp_tready low for a random gap, a long hold when requested, or not at all
   initial begin : rsp_ready_driver
      int gap;
      do @(posedge clock); while (reset);
      rsp_tready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         if (rsp_long_hold) begin
            gap = LONG_HOLD_CYCLES;
            rsp_long_hold = 1'b0;
         end else begin
            gap = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_request(
      input gdda_pkg::opcode_type op,
      input logic [13:0]          year,
      input logic [3:0]           month,
      input logic [4:0]           day,
      input logic [11:0]          delta
   );
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, delta, day, month, year};
      do @(posedge clock); while (!req_tready);
      expected_dates.push_back(apply_calendar_step(op, year, month, day, delta));
      op_counts[op]++;
   endtask

   // Hold off new requests until every outstanding result has arrived
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   // Well-formed dates dominate; years near both ends push arithmetic over the edge
   task automatic send_random_request();
      gdda_pkg::opcode_type op;
      logic [13:0]          y;
      logic [3:0]           m;
      logic [4:0]           d;
      logic [11:0]          delta;
      int                   pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = gdda_pkg::OP_LOAD;
      else if (pick < 60) op = gdda_pkg::OP_ADD;
      else if (pick < 90) op = gdda_pkg::OP_SUB;
      else                op = gdda_pkg::OP_QUERY;

      // Random filler in the unused fields
      y = 14'($urandom);
      m = 4'($urandom);
      d = 5'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 50)      delta = 12'($urandom);
      else if (pick < 75) delta = 12'($urandom_range(0, 40));
      else                delta = 12'($urandom_range(28, 400));

      if (op == gdda_pkg::OP_LOAD && $urandom_range(0, 99) < 75) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)      y = 14'($urandom_range(1, 15));
         else if (pick < 30) y = 14'($urandom_range(9985, 9999));
         else                y = 14'($urandom_range(1, 9999));
         m = 4'($urandom_range(1, 12));
         d = 5'($urandom_range(1, month_days(int'(m), int'(y))));
      end
      send_request(op, y, m, d, delta);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_and_loads();
      send_request(gdda_pkg::OP_QUERY, 14'd0,     4'd0,  5'd0,  12'd0);   // reset date
      send_request(gdda_pkg::OP_LOAD,  14'd2000,  4'd2,  5'd29, 12'd0);   // leap by 400
      send_request(gdda_pkg::OP_LOAD,  14'd1900,  4'd2,  5'd29, 12'd0);   // century, not leap
      send_request(gdda_pkg::OP_LOAD,  14'd2000,  4'd0,  5'd0,  12'd0);   // month before day
      send_request(gdda_pkg::OP_LOAD,  14'd2000,  4'd13, 5'd10, 12'd0);
      send_request(gdda_pkg::OP_LOAD,  14'd16383, 4'd15, 5'd31, 12'd4095);
      send_request(gdda_pkg::OP_LOAD,  14'd2023,  4'd4,  5'd31, 12'd0);   // short month
      send_request(gdda_pkg::OP_LOAD,  14'd2023,  4'd6,  5'd0,  12'd0);   // day zero
      send_request(gdda_pkg::OP_LOAD,  14'd0,     4'd1,  5'd1,  12'd0);   // year zero
      send_request(gdda_pkg::OP_LOAD,  14'd10000, 4'd12, 5'd31, 12'd0);
      send_request(gdda_pkg::OP_LOAD,  14'd16383, 4'd1,  5'd1,  12'd0);
      send_request(gdda_pkg::OP_LOAD,  14'd2400,  4'd2,  5'd29, 12'd0);
      send_request(gdda_pkg::OP_LOAD,  14'd2100,  4'd2,  5'd29, 12'd0);
   endtask

   task automatic test_arithmetic_edges();
      send_request(gdda_pkg::OP_LOAD,  14'd9999, 4'd12, 5'd31, 12'd0);
      send_request(gdda_pkg::OP_ADD,   14'd0,    4'd0,  5'd0,  12'd1);    // past the last year
      send_request(gdda_pkg::OP_ADD,   14'd0,    4'd0,  5'd0,  12'd0);
      send_request(gdda_pkg::OP_SUB,   14'd0,    4'd0,  5'd0,  12'd4095);
      send_request(gdda_pkg::OP_LOAD,  14'd1,    4'd1,  5'd1,  12'd0);
      send_request(gdda_pkg::OP_SUB,   14'd0,    4'd0,  5'd0,  12'd1);    // before the first year
      send_request(gdda_pkg::OP_SUB,   14'd0,    4'd0,  5'd0,  12'd0);
      send_request(gdda_pkg::OP_ADD,   14'd0,    4'd0,  5'd0,  12'd4095);
      send_request(gdda_pkg::OP_LOAD,  14'd2024, 4'd1,  5'd31, 12'd0);
      send_request(gdda_pkg::OP_ADD,   14'd0,    4'd0,  5'd0,  12'd29);   // lands on leap day
      send_request(gdda_pkg::OP_SUB,   14'd0,    4'd0,  5'd0,  12'd4095);
      send_request(gdda_pkg::OP_QUERY, 14'h3FFF, 4'hF,  5'h1F, 12'hFFF);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_request();
   endtask

   task automatic test_no_idle(input int count);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      repeat (count) send_random_request();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Stall the result side for a long stretch while requests keep coming
   task automatic test_output_backpressure(input int count);
      req_gaps_on   = 1'b0;
      rsp_long_hold = 1'b1;
      repeat (count) send_random_request();
      req_gaps_on   = 1'b1;
   endtask

   task automatic test_drain_pauses(input int rounds, input int per_round);
      repeat (rounds) begin
         repeat (per_round) send_random_request();
         wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main_sequence
      cal_year  = gdda_pkg::RESET_YEAR;
      cal_month = gdda_pkg::RESET_MONTH;
      cal_day   = gdda_pkg::RESET_DAY;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_and_loads();
      test_arithmetic_edges();
      test_random_mix(RANDOM_ITEMS);
      test_no_idle(80);
      test_output_backpressure(40);
      test_drain_pauses(4, 20);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d loads, %0d adds, %0d subtracts, %0d queries; %0d results checked",
               op_counts[gdda_pkg::OP_LOAD], op_counts[gdda_pkg::OP_ADD],
               op_counts[gdda_pkg::OP_SUB], op_counts[gdda_pkg::OP_QUERY], results_seen);
      $display("Status seen: ok %0d, bad month %0d, bad day %0d, year out of range %0d",
               status_hits[gdda_pkg::STATUS_OK], status_hits[gdda_pkg::STATUS_BAD_MONTH],
               status_hits[gdda_pkg::STATUS_BAD_DAY], status_hits[gdda_pkg::STATUS_BAD_YEAR]);
      if (mismatch_count == 0 && expected_dates.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
